// ----- src/dcfp_pkg.sv -----
// dcfp_pkg: shared types and constants for the delimited command frame parser
// holds the config register set, result item layout, result kinds and controller states
// no dependencies
package dcfp_pkg;

	// config register indexes
	localparam logic [1:0] REG_START_MARKER    = 2'd0;
	localparam logic [1:0] REG_END_MARKER      = 2'd1;
	localparam logic [1:0] REG_TEMPERATURE_TAG = 2'd2;
	localparam logic [1:0] REG_SWEEP_TAG       = 2'd3;

	// config reset values
	localparam logic [7:0] START_MARKER_RST    = 8'd2;
	localparam logic [7:0] END_MARKER_RST      = 8'd3;
	localparam logic [7:0] TEMPERATURE_TAG_RST = 8'd1;
	localparam logic [7:0] SWEEP_TAG_RST       = 8'd2;

	// sweep level value is the payload byte times four
	localparam int unsigned LEVEL_SHIFT = 2;

	typedef enum logic [1:0] {
		KIND_TEMP  = 2'd0,
		KIND_LEVEL = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_ERR,
		ST_TAG,
		ST_TEMP,
		ST_SWEEP
	} state_t;

	typedef struct packed {
		logic [7:0] start_marker;
		logic [7:0] end_marker;
		logic [7:0] temperature_tag;
		logic [7:0] sweep_tag;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  temperature;
		logic [7:0]  previous_temperature;
		logic [2:0]  level_index;
		logic [9:0]  level_value;
		logic        last;
	} result_t;

endpackage

// ----- src/dcfp_ram.sv -----
// dcfp_ram: generic single-clock ram with one write port and one registered read port
// read data updates only on a read enable and holds otherwise
// no dependencies
module dcfp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/dcfp_outreg.sv -----
// dcfp_outreg: output register between the controller and the result channel
// takes a new result item whenever it is empty or its item is taken in the same cycle
// depends on dcfp_pkg
module dcfp_outreg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dcfp_pkg::result_t push_data,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output dcfp_pkg::result_t out_data
);
	import dcfp_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (free && push) begin
			data_q <= push_data;
		end
	end

endmodule

// ----- src/dcfp_ctrl.sv -----
// dcfp_ctrl: frame hunting, payload collection into the store and frame dispatch sequencer
// writes payload bytes into the ram while collecting, reads them back to dispatch, one per cycle while out_free
// depends on dcfp_pkg
module dcfp_ctrl #(
	parameter int unsigned PAYLOAD_DEPTH = 16,
	parameter int unsigned LEVEL_COUNT   = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dcfp_pkg::cfg_t                   cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       rx_byte,
	output logic                             ram_we,
	output logic [$clog2(PAYLOAD_DEPTH)-1:0] ram_waddr,
	output logic [7:0]                       ram_wdata,
	output logic                             ram_re,
	output logic [$clog2(PAYLOAD_DEPTH)-1:0] ram_raddr,
	input  logic [7:0]                       ram_rdata,
	input  logic                             out_free,
	output logic                             push,
	output dcfp_pkg::result_t                push_data
);
	import dcfp_pkg::*;

	localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);
	localparam int unsigned CW = $clog2(PAYLOAD_DEPTH + 1);
	localparam int unsigned LW = $clog2(LEVEL_COUNT + 1);
	localparam bit          SWEEP_OK = (LEVEL_COUNT < PAYLOAD_DEPTH);
	localparam logic [CW-1:0] SWEEP_MIN =
		CW'(SWEEP_OK ? LEVEL_COUNT + 1 : PAYLOAD_DEPTH);
	localparam logic [CW-1:0] TEMP_MIN  = CW'(2);
	localparam logic [CW-1:0] FULL      = CW'(PAYLOAD_DEPTH);
	localparam logic [LW-1:0] LAST_LVL  = LW'(LEVEL_COUNT - 1);

	state_t        state_q, state_d;
	logic          in_frame_q, in_frame_d;
	logic [CW-1:0] count_q, count_d;
	logic [LW-1:0] lvl_q, lvl_d;
	logic [7:0]    cur_q, cur_d;
	logic [7:0]    prev_q, prev_d;
	logic [LW:0]   lvl_plus2;
	logic          lvl_last;

	assign lvl_plus2 = {1'b0, lvl_q} + (LW + 1)'(2);
	assign lvl_last  = (lvl_q == LAST_LVL);
	assign ram_wdata = rx_byte;
	assign ram_waddr = AW'(count_q);

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			in_frame_q <= 1'b0;
			count_q    <= '0;
			lvl_q      <= '0;
			cur_q      <= '0;
			prev_q     <= '0;
		end else begin
			state_q    <= state_d;
			in_frame_q <= in_frame_d;
			count_q    <= count_d;
			lvl_q      <= lvl_d;
			cur_q      <= cur_d;
			prev_q     <= prev_d;
		end
	end

	// next state, ram access and result item
	// writes happen only while collecting and reads only on the end byte or while dispatching,
	// so the two never touch the ram in the same cycle
	always_comb begin
		state_d    = state_q;
		in_frame_d = in_frame_q;
		count_d    = count_q;
		lvl_d      = lvl_q;
		cur_d      = cur_q;
		prev_d     = prev_q;
		in_ready   = (state_q == ST_RUN);
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		push       = 1'b0;
		push_data  = '{kind: KIND_ERROR, temperature: cur_q, previous_temperature: prev_q,
			level_index: 3'd0, level_value: 10'd0, last: 1'b1};

		unique case (state_q)
			ST_RUN: begin
				if (in_valid) begin
					if (!in_frame_q) begin
						// hunting for the start byte
						if (rx_byte == cfg.start_marker) begin
							in_frame_d = 1'b1;
							count_d    = '0;
						end
					end else if (rx_byte == cfg.end_marker) begin
						// frame complete: fetch the tag byte, or flag an empty frame as an error
						in_frame_d = 1'b0;
						if (count_q == '0) begin
							state_d = ST_ERR;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = '0;
							state_d   = ST_TAG;
						end
					end else if (count_q >= FULL) begin
						// overflow drops the byte and reports an error
						in_frame_d = 1'b0;
						state_d    = ST_ERR;
					end else begin
						ram_we  = 1'b1;
						count_d = count_q + CW'(1);
					end
				end
			end
			ST_ERR: begin
				if (out_free) begin
					push    = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_TAG: begin
				// tag byte is on the read port; temperature wins on equal tags
				if (ram_rdata == cfg.temperature_tag) begin
					if (count_q >= TEMP_MIN) begin
						ram_re    = 1'b1;
						ram_raddr = AW'(1);
						state_d   = ST_TEMP;
					end else begin
						state_d = ST_ERR;
					end
				end else if (ram_rdata == cfg.sweep_tag && SWEEP_OK && count_q >= SWEEP_MIN) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(1);
					lvl_d     = '0;
					state_d   = ST_SWEEP;
				end else begin
					state_d = ST_ERR;
				end
			end
			ST_TEMP: begin
				if (out_free) begin
					push                           = 1'b1;
					push_data.kind                 = KIND_TEMP;
					push_data.temperature          = ram_rdata;
					push_data.previous_temperature = cur_q;
					prev_d                         = cur_q;
					cur_d                          = ram_rdata;
					state_d                        = ST_RUN;
				end
			end
			ST_SWEEP: begin
				// one level per cycle while out_free, the next byte is read as this one leaves
				if (out_free) begin
					push                  = 1'b1;
					push_data.kind        = KIND_LEVEL;
					push_data.level_index = 3'(lvl_q);
					push_data.level_value = 10'(ram_rdata) << LEVEL_SHIFT;
					push_data.last        = lvl_last;
					if (lvl_last) begin
						state_d = ST_RUN;
					end else begin
						lvl_d     = lvl_q + LW'(1);
						ram_re    = 1'b1;
						ram_raddr = AW'(lvl_plus2);
					end
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

endmodule

// ----- src/delimited_command_frame_parser.sv -----
// Delimited command frame parser: hunts for a start byte, collects payload bytes
// into a ram until the end byte, then dispatches the frame as temperature, sweep or error.
//
// Input channel: in_valid/in_ready with rx_byte, one item per cycle while collecting.
// Output channel: out_valid/out_ready with the result fields, held in an output register.
// Config port: cfg_wr_en/cfg_addr/cfg_wr_data; user writes only while idle, not enforced.
//
// A byte that opens, fills or is discarded causes no result. The end byte, or a byte
// that overflows the payload ram, stops intake for the dispatch, which walks the payload
// ram one entry per cycle, while the output register is free, through its registered read
// port: an empty, short or overflowed frame or bad tag is an error, a temperature frame reads
// the temperature byte, a sweep LEVEL_COUNT level bytes; each result is registered in the
// output register. When the receiver stalls, the output register holds its item and the
// dispatcher waits; byte intake continues while a finished result waits to be taken.
// Reset clears the frame state, temperatures and output valid and loads config defaults;
// the payload ram needs no clearing since every entry read was written in the same frame.
// depends on dcfp_pkg, dcfp_ram, dcfp_ctrl, dcfp_outreg
module delimited_command_frame_parser #(
	parameter int unsigned PAYLOAD_DEPTH = 16,
	parameter int unsigned LEVEL_COUNT   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_addr,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] result_kind,
	output logic [7:0] temperature,
	output logic [7:0] previous_temperature,
	output logic [2:0] level_index,
	output logic [9:0] level_value,
	output logic       last
);
	import dcfp_pkg::*;

	localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);

	cfg_t          cfg_q;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic          out_free, push;
	result_t       push_data, out_data;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{start_marker: START_MARKER_RST, end_marker: END_MARKER_RST,
				temperature_tag: TEMPERATURE_TAG_RST, sweep_tag: SWEEP_TAG_RST};
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_START_MARKER:    cfg_q.start_marker    <= cfg_wr_data;
				REG_END_MARKER:      cfg_q.end_marker      <= cfg_wr_data;
				REG_TEMPERATURE_TAG: cfg_q.temperature_tag <= cfg_wr_data;
				REG_SWEEP_TAG:       cfg_q.sweep_tag       <= cfg_wr_data;
				default: begin
				end
			endcase
		end
	end

	// payload store
	dcfp_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// frame controller
	dcfp_ctrl #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH),
		.LEVEL_COUNT  (LEVEL_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_free  (out_free),
		.push      (push),
		.push_data (push_data)
	);

	// result output register
	dcfp_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign result_kind          = out_data.kind;
	assign temperature          = out_data.temperature;
	assign previous_temperature = out_data.previous_temperature;
	assign level_index          = out_data.level_index;
	assign level_value          = out_data.level_value;
	assign last                 = out_data.last;

endmodule

// ----- src/dcfp_checker.sv -----
// dcfp_checker: port-level assertions for the delimited command frame parser
// bound to the top level; depends on dcfp_pkg
module dcfp_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] result_kind,
	input  logic [7:0] temperature,
	input  logic [7:0] previous_temperature,
	input  logic [2:0] level_index,
	input  logic [9:0] level_value,
	input  logic       last
);
	import dcfp_pkg::*;

	logic       out_take;
	logic [7:0] seen_temp_q;
	logic [7:0] seen_prev_q;

	assign out_take = out_valid && out_ready;

	// temperatures of the last item taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_temp_q <= '0;
			seen_prev_q <= '0;
		end else if (out_take) begin
			seen_temp_q <= temperature;
			seen_prev_q <= previous_temperature;
		end
	end

	// an offered input item holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(rx_byte))
		else $error("input item changed while waiting");

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
		$stable(temperature) && $stable(previous_temperature) &&
		$stable(level_index) && $stable(level_value) && $stable(last))
		else $error("result item changed while stalled");

	// only a temperature update changes the temperatures
	a_temp_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && result_kind != KIND_TEMP |->
		temperature == seen_temp_q && previous_temperature == seen_prev_q)
		else $error("temperatures changed without a temperature update");

	// a temperature update moves the old value to previous
	a_temp_shift: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && result_kind == KIND_TEMP |-> previous_temperature == seen_temp_q)
		else $error("previous temperature is not the prior value");

	// intake waits while a sweep is still draining
	a_sweep_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && result_kind == KIND_LEVEL && !last |-> !in_ready)
		else $error("input accepted during a sweep");

endmodule

bind delimited_command_frame_parser dcfp_checker u_dcfp_checker (.*);
